// ===== hw/rtl/sxb_pkg.sv =====
// Shared constants, types and helpers of the horizontal Sobel blend filter.
package sxb_pkg;

  localparam int MAX_LINE   = 1024;
  localparam int ROWS_MAX   = 1024;
  localparam int PIX_BITS   = 8;
  localparam int CFG_BITS   = 11;
  localparam int IDX_BITS   = 8;
  localparam int OUT_BITS   = 11;
  localparam int MIN_DIM    = 3;
  localparam int LEN_RESET  = 100;
  localparam int ROWS_RESET = 100;

  localparam int ADDR_BITS  = $clog2(MAX_LINE);
  localparam int LEN_BITS   = $clog2(MAX_LINE + 1);
  localparam int HGT_BITS   = $clog2(ROWS_MAX + 1);
  localparam int ROW_BITS   = $clog2(ROWS_MAX + 2);
  localparam int SUM_BITS   = PIX_BITS + 2;
  localparam int T_BITS     = PIX_BITS + 4;

  typedef enum logic [IDX_BITS-1:0] {
    REG_LINE_LENGTH = IDX_BITS'(0),
    REG_FRAME_ROWS  = IDX_BITS'(1)
  } sxb_reg_e;

  // one window column: row above, current row, row below
  typedef struct packed {
    logic [PIX_BITS-1:0] up;
    logic [PIX_BITS-1:0] mid;
    logic [PIX_BITS-1:0] low;
  } col_t;

  typedef struct packed {
    logic zero;
    logic top;
    logic bot;
  } col_mask_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] filtered;
    logic                       frame_end;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } oq_ctrl_t;

  // 1,2,1 weighted column sum with border rows masked out
  function automatic logic [SUM_BITS-1:0] col_sum(col_t c, col_mask_t m);
    logic [SUM_BITS-1:0] s;
    s = '0;
    if (!m.zero) begin
      s = {1'b0, c.mid, 1'b0};
      if (!m.top) begin
        s = s + SUM_BITS'(c.up);
      end
      if (!m.bot) begin
        s = s + SUM_BITS'(c.low);
      end
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/sxb_pix_if.sv =====
// Pixel input channel: valid/ready handshake with pixel and flush payload.
interface sxb_pix_if import sxb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PIX_BITS-1:0] pixel;
  logic                flush;

  modport source (output valid, output pixel, output flush, input ready);
  modport sink   (input valid, input pixel, input flush, output ready);
endinterface

// ===== hw/rtl/sxb_res_if.sv =====
// Result output channel: valid/ready handshake with filtered value and frame end.
interface sxb_res_if import sxb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] filtered;
  logic                       frame_end;

  modport source (output valid, output filtered, output frame_end, input ready);
  modport sink   (input valid, input filtered, input frame_end, output ready);
endinterface

// ===== hw/rtl/sxb_cfg_if.sv =====
// Configuration write channel: valid/ready handshake with register index and data.
interface sxb_cfg_if import sxb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IDX_BITS-1:0] index;
  logic [CFG_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/sxb_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
module sxb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sxb_col_cell.sv =====
// Window column cell: holds one 3-pixel column and passes it on to its neighbor.
module sxb_col_cell import sxb_pkg::*; (
  input  logic clk_i,
  input  logic shift_i,
  input  col_t col_i,
  output col_t col_o
);

  col_t col_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== hw/rtl/sxb_out_q.sv =====
// Two-entry result queue that decouples the filter pipeline from the receiver.
module sxb_out_q import sxb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  oq_ctrl_t   ctrl_i,
  input  res_t       data_i,
  output res_t       head_o,
  output logic [1:0] count_o
);

  logic [1:0] count_q, count_d;
  res_t       slot0_q, slot1_q;

  assign count_d = count_q + {1'b0, ctrl_i.push} - {1'b0, ctrl_i.pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case ({ctrl_i.push, ctrl_i.pop})
      2'b10: begin
        if (count_q == 2'd0) begin
          slot0_q <= data_i;
        end else begin
          slot1_q <= data_i;
        end
      end
      2'b01: begin
        slot0_q <= slot1_q;
      end
      2'b11: begin
        if (count_q == 2'd1) begin
          slot0_q <= data_i;
        end else begin
          slot0_q <= slot1_q;
          slot1_q <= data_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign head_o  = slot0_q;
  assign count_o = count_q;

endmodule

// ===== hw/rtl/sobel_x_blend_filter.sv =====
// Top level of the horizontal Sobel blend filter over a raster pixel stream.
//
// Channels: pix_i takes one pixel item (pixel, flush) per cycle while ready, in
// raster order; res_o gives filtered = (p + 1 + gx) / 2 with frame_end on the last
// result of a frame; cfg_i writes line_length (index 0) or frame_rows (index 1),
// clamped to [3, 1024]. Any known write restarts the frame position at zero.
// Throughput: one item per cycle while pix_i.ready is high, set by the single read
// and write port of each line store; the two window column cells shift once per item.
// Latency: the result for a pixel leaves after line_length + 1 further items; an
// item that causes a result is registered in b_q and then in the output queue before res_o.
// After the last row, line_length + 1 flush items drain the frame; flush items
// inside the frame are taken and dropped, pixels during the drain count as flush.
// Reset: both registers return to 100 and the position to zero; line store and
// window contents are left as they are, border masking hides them.
// Stall: results wait in a two-entry queue; pix_i.ready drops only when the queue
// and the item in flight would fill it and no result is popped. cfg_i.ready is always high.
module sobel_x_blend_filter import sxb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sxb_pix_if.sink   pix_i,
  sxb_res_if.source res_o,
  sxb_cfg_if.sink   cfg_i
);

  typedef struct packed {
    logic [PIX_BITS-1:0]  pix;
    logic [ADDR_BITS-1:0] addr;
    logic                 emit;
    logic                 last;
    col_mask_t            lmask;
    col_mask_t            rmask;
  } stage_t;

  function automatic int clamp_dim(logic [CFG_BITS-1:0] v, int hi);
    if (int'(v) < MIN_DIM) begin
      return MIN_DIM;
    end
    if (int'(v) > hi) begin
      return hi;
    end
    return int'(v);
  endfunction

  logic [LEN_BITS-1:0]  len_q, len_d;
  logic [HGT_BITS-1:0]  rows_q, rows_d;
  logic [ADDR_BITS-1:0] col_q, col_d;
  logic [ROW_BITS-1:0]  row_q, row_d;
  logic                 b_valid_q;
  stage_t               b_q, b_d;

  logic                 cfg_fire, cfg_known, pix_fire, work, draining;
  logic                 c_nz, wrap;
  logic [ROW_BITS-1:0]  h_ext;
  logic [LEN_BITS-1:0]  col_inc;
  logic [PIX_BITS-1:0]  rd_a, rd_b;
  col_t                 in_col, cell_c_col, cell_l_col;
  logic [SUM_BITS-1:0]  sum_l, sum_r;
  logic signed [T_BITS-1:0] t_sum, t_rnd, t_half;
  res_t                 res_new, res_head;
  oq_ctrl_t             oq_ctrl;
  logic [1:0]           oq_count;
  logic [2:0]           occ;
  logic                 pop;

  // configuration
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign cfg_known   = (cfg_i.index == REG_LINE_LENGTH) || (cfg_i.index == REG_FRAME_ROWS);

  always_comb begin
    len_d  = len_q;
    rows_d = rows_q;
    if (cfg_fire) begin
      unique case (sxb_reg_e'(cfg_i.index))
        REG_LINE_LENGTH: len_d  = LEN_BITS'(clamp_dim(cfg_i.data, MAX_LINE));
        REG_FRAME_ROWS:  rows_d = HGT_BITS'(clamp_dim(cfg_i.data, ROWS_MAX));
        default: begin
        end
      endcase
    end
  end

  // frame position and per-item flags
  assign h_ext    = ROW_BITS'(rows_q);
  assign draining = row_q >= h_ext;
  assign pix_fire = pix_i.valid && pix_i.ready;
  assign work     = pix_fire && (draining || !pix_i.flush);
  assign c_nz     = col_q != '0;
  assign col_inc  = LEN_BITS'(col_q) + LEN_BITS'(1);
  assign wrap     = col_inc == len_q;

  always_comb begin
    b_d.pix        = draining ? '0 : pix_i.pixel;
    b_d.addr       = col_q;
    b_d.emit       = (row_q >= ROW_BITS'(1)) && (c_nz || (row_q >= ROW_BITS'(2)));
    b_d.last       = !c_nz && (row_q == h_ext + ROW_BITS'(1));
    b_d.lmask.zero = col_q == ADDR_BITS'(1);
    b_d.lmask.top  = c_nz ? (row_q == ROW_BITS'(1)) : (row_q == ROW_BITS'(2));
    b_d.lmask.bot  = c_nz ? (row_q >= h_ext) : (row_q >= h_ext + ROW_BITS'(1));
    b_d.rmask.zero = !c_nz;
    b_d.rmask.top  = b_d.lmask.top;
    b_d.rmask.bot  = b_d.lmask.bot;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    priority if (cfg_fire && cfg_known) begin
      col_d = '0;
      row_d = '0;
    end else if (work) begin
      if (b_d.last) begin
        col_d = '0;
        row_d = '0;
      end else if (wrap) begin
        col_d = '0;
        row_d = row_q + ROW_BITS'(1);
      end else begin
        col_d = col_inc[ADDR_BITS-1:0];
      end
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= LEN_BITS'(LEN_RESET);
      rows_q    <= HGT_BITS'(ROWS_RESET);
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      len_q     <= len_d;
      rows_q    <= rows_d;
      col_q     <= col_d;
      row_q     <= row_d;
      b_valid_q <= work;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      b_q <= b_d;
    end
  end

  // line stores: a holds the previous row, b the one before
  sxb_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_LINE)) u_store_a (
    .clk_i  (clk_i),
    .we_i   (b_valid_q),
    .waddr_i(b_q.addr),
    .wdata_i(b_q.pix),
    .raddr_i(col_q),
    .rdata_o(rd_a)
  );

  sxb_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_LINE)) u_store_b (
    .clk_i  (clk_i),
    .we_i   (b_valid_q),
    .waddr_i(b_q.addr),
    .wdata_i(rd_a),
    .raddr_i(col_q),
    .rdata_o(rd_b)
  );

  // window: incoming column -> center cell -> left cell
  assign in_col = '{up: rd_b, mid: rd_a, low: b_q.pix};

  sxb_col_cell u_cell_c (
    .clk_i  (clk_i),
    .shift_i(b_valid_q),
    .col_i  (in_col),
    .col_o  (cell_c_col)
  );

  sxb_col_cell u_cell_l (
    .clk_i  (clk_i),
    .shift_i(b_valid_q),
    .col_i  (cell_c_col),
    .col_o  (cell_l_col)
  );

  assign sum_l  = col_sum(cell_l_col, b_q.lmask);
  assign sum_r  = col_sum(in_col, b_q.rmask);
  assign t_sum  = $signed({2'b00, sum_r}) - $signed({2'b00, sum_l})
                + $signed({4'b0000, cell_c_col.mid}) + T_BITS'(1);
  // halve with truncation toward zero
  assign t_rnd  = t_sum + T_BITS'(t_sum[T_BITS-1]);
  assign t_half = t_rnd >>> 1;

  assign res_new.filtered  = t_half[OUT_BITS-1:0];
  assign res_new.frame_end = b_q.last;

  // output queue and flow control
  assign pop          = res_o.valid && res_o.ready;
  assign oq_ctrl.push = b_valid_q && b_q.emit;
  assign oq_ctrl.pop  = pop;

  sxb_out_q u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (oq_ctrl),
    .data_i (res_new),
    .head_o (res_head),
    .count_o(oq_count)
  );

  assign res_o.valid     = oq_count != 2'd0;
  assign res_o.filtered  = res_head.filtered;
  assign res_o.frame_end = res_head.frame_end;

  assign occ         = {1'b0, oq_count} + {2'b00, b_valid_q};
  assign pix_i.ready = (occ < 3'd2) || ((occ == 3'd2) && pop);

  // assertions
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ <= 3'd2)
    else $error("result queue overcommitted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    work |=> b_valid_q)
    else $error("accepted pixel item lost before the window stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_fire && cfg_known) |=> (col_q == '0) && (row_q == '0))
    else $error("register write did not restart the frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_q.last) |-> b_q.emit)
    else $error("frame end marked on an item without a result");

endmodule
